// ===== rtl/pae_pkg.sv =====
// pae_pkg: shared types and constants for the positional array editor.
// Holds word structs, operation and status codes, controller/datapath interface.
// No dependencies.
package pae_pkg;

  localparam int ITEMS_DEF     = 1024;
  localparam int WORD_BITS_DEF = 32;
  localparam int POS_W         = 11;
  localparam int VAL_W         = 32;
  localparam int CNT_OUT_W     = 11;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SWAP   = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  typedef struct packed {
    logic [1:0]              operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        first_start;
    logic [POS_W-1:0]        first_end;
    logic [POS_W-1:0]        second_start;
    logic [POS_W-1:0]        second_end;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [CNT_OUT_W-1:0]    item_count;
    logic [1:0]              status;
  } out_word_t;

  typedef struct packed {
    logic latch;
    logic decide;
    logic move;
    logic fill;
    logic copy;
    logic put;
    logic resp;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       err;
    logic       need_move;
    logic       last;
  } dp_stat_t;

endpackage

// ===== rtl/pae_ram.sv =====
// pae_ram: generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module pae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/pae_ctrl.sv =====
// pae_ctrl: sequencing state machine of the positional array editor.
// Depends on pae_pkg (dp_cmd_t, dp_stat_t, operation codes).
module pae_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pae_pkg::dp_stat_t stat,
  output pae_pkg::dp_cmd_t  cmd
);
  import pae_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECIDE = 8'b0000_0010,
    S_MOVE   = 8'b0000_0100,
    S_FLUSH  = 8'b0000_1000,
    S_PUT    = 8'b0001_0000,
    S_FILL   = 8'b0010_0000,
    S_COPY   = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.latch = start;
        if (start) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (stat.err) begin
          state_nxt = S_RESP;
        end else begin
          case (stat.op)
            OP_INSERT: state_nxt = stat.need_move ? S_MOVE : S_PUT;
            OP_DELETE: state_nxt = stat.need_move ? S_MOVE : S_RESP;
            OP_SWAP:   state_nxt = S_FILL;
            default:   state_nxt = S_RESP;
          endcase
        end
      end
      S_MOVE: begin
        cmd.move = 1'b1;
        if (stat.last) begin
          state_nxt = (stat.op == OP_INSERT) ? S_FLUSH : S_RESP;
        end
      end
      S_FLUSH: begin
        state_nxt = S_PUT;
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = S_RESP;
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (stat.last) begin
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (stat.last) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        cmd.resp  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== rtl/pae_dp.sv =====
// pae_dp: datapath of the positional array editor: entry store, scratch store,
// address counters, count register and result register. Depends on pae_pkg, pae_ram.
module pae_dp #(
  parameter int ITEMS     = pae_pkg::ITEMS_DEF,
  parameter int WORD_BITS = pae_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pae_pkg::in_word_t  in_word,
  input  pae_pkg::dp_cmd_t   cmd,
  output pae_pkg::dp_stat_t  stat,
  output logic               out_valid,
  output pae_pkg::out_word_t out_word
);
  import pae_pkg::*;

  localparam int AW = $clog2(ITEMS);
  localparam int CW = $clog2(ITEMS + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [1:0] {
    PW_NONE,
    PW_SHIFT,
    PW_FILL,
    PW_COPY
  } pend_t;

  in_word_t  req_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] last_r, last_nxt;
  logic [1:0]    seg_r, seg_nxt;
  pend_t         pend_r, pend_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  logic          out_valid_r;
  out_word_t     out_word_r;

  logic [PW-1:0] n_w, pos_w, s1_w, e1_w, s2_w, e2_w, p_w, at_w;
  logic [AW-1:0] at_a, e2m1, s2m2, e1a, s1m1, swap_next;
  logic [1:0]    swap_seg;
  logic          swap_ok, mid, is_ins;
  logic [1:0]    st_code;
  logic          need_move;

  logic                 st_we, sc_we;
  logic [AW-1:0]        st_waddr, st_raddr;
  logic [WORD_BITS-1:0] st_wdata, st_rdata, sc_rdata;
  logic [63:0]          v64, ext64;
  logic signed [WORD_BITS-1:0] st_s;

  assign n_w   = PW'(count_r);
  assign pos_w = PW'(req_r.position);
  assign s1_w  = PW'(req_r.first_start);
  assign e1_w  = PW'(req_r.first_end);
  assign s2_w  = PW'(req_r.second_start);
  assign e2_w  = PW'(req_r.second_end);
  assign is_ins = (req_r.operation == OP_INSERT);

  always_comb begin
    p_w = (pos_w > n_w) ? n_w : pos_w;
    if (p_w == '0) begin
      p_w = PW'(1);
    end
    at_w = (n_w == '0) ? '0 : (p_w - PW'(1));
  end

  assign at_a    = AW'(at_w);
  assign swap_ok = (s1_w != '0) && (s1_w <= e1_w) && (e1_w < s2_w) &&
                   (s2_w <= e2_w) && (e2_w <= n_w);

  always_comb begin
    st_code   = ST_OK;
    need_move = 1'b0;
    case (req_r.operation)
      OP_INSERT: begin
        if (count_r == CW'(ITEMS)) st_code = ST_FULL;
        need_move = (n_w > at_w);
      end
      OP_DELETE: begin
        if (count_r == '0) st_code = ST_EMPTY;
        need_move = ((at_w + PW'(1)) < n_w);
      end
      OP_SWAP: begin
        if (!swap_ok) st_code = ST_BAD;
      end
      default: begin
        if (count_r == '0) st_code = ST_EMPTY;
      end
    endcase
  end

  assign stat.op        = req_r.operation;
  assign stat.err       = (st_code != ST_OK);
  assign stat.need_move = need_move;
  assign stat.last      = (idx_r == last_r);

  // swap source walk: second range, then middle, then first range
  assign e2m1 = AW'(e2_w - PW'(1));
  assign s2m2 = AW'(s2_w - PW'(2));
  assign e1a  = AW'(e1_w);
  assign s1m1 = AW'(s1_w - PW'(1));
  assign mid  = ((e1_w + PW'(1)) < s2_w);

  always_comb begin
    swap_next = addr_r + AW'(1);
    swap_seg  = seg_r;
    case (seg_r)
      2'd0: begin
        if (addr_r == e2m1) begin
          swap_next = mid ? e1a : s1m1;
          swap_seg  = mid ? 2'd1 : 2'd2;
        end
      end
      2'd1: begin
        if (addr_r == s2m2) begin
          swap_next = s1m1;
          swap_seg  = 2'd2;
        end
      end
      default: begin
        swap_seg = seg_r;
      end
    endcase
  end

  always_comb begin
    addr_nxt      = addr_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    seg_nxt       = seg_r;
    pend_nxt      = PW_NONE;
    pend_addr_nxt = pend_addr_r;
    if (cmd.decide) begin
      idx_nxt = '0;
      seg_nxt = 2'd0;
      case (req_r.operation)
        OP_INSERT: begin
          addr_nxt = AW'(n_w - PW'(1));
          last_nxt = AW'(n_w - at_w - PW'(1));
        end
        OP_DELETE: begin
          addr_nxt = AW'(at_w + PW'(1));
          last_nxt = AW'(n_w - at_w - PW'(2));
        end
        OP_SWAP: begin
          addr_nxt = AW'(s2_w - PW'(1));
          last_nxt = AW'(e2_w - s1_w);
        end
        default: begin
          addr_nxt = addr_r;
        end
      endcase
    end else if (cmd.move) begin
      pend_nxt      = PW_SHIFT;
      pend_addr_nxt = is_ins ? (addr_r + AW'(1)) : (addr_r - AW'(1));
      addr_nxt      = is_ins ? (addr_r - AW'(1)) : (addr_r + AW'(1));
      idx_nxt       = idx_r + AW'(1);
    end else if (cmd.fill) begin
      pend_nxt      = PW_FILL;
      pend_addr_nxt = idx_r;
      addr_nxt      = swap_next;
      seg_nxt       = swap_seg;
      idx_nxt       = stat.last ? '0 : (idx_r + AW'(1));
    end else if (cmd.copy) begin
      pend_nxt      = PW_COPY;
      pend_addr_nxt = s1m1 + idx_r;
      idx_nxt       = idx_r + AW'(1);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.resp && !stat.err) begin
      if (req_r.operation == OP_INSERT) begin
        count_nxt = count_r + CW'(1);
      end else if (req_r.operation == OP_DELETE) begin
        count_nxt = count_r - CW'(1);
      end
    end
  end

  assign v64      = 64'($unsigned(req_r.value));
  assign st_we    = (pend_r == PW_SHIFT) || (pend_r == PW_COPY) || cmd.put;
  assign st_waddr = cmd.put ? at_a : pend_addr_r;
  assign st_wdata = cmd.put ? v64[WORD_BITS-1:0] :
                    ((pend_r == PW_COPY) ? sc_rdata : st_rdata);
  assign st_raddr = cmd.decide ? at_a : addr_r;
  assign sc_we    = (pend_r == PW_FILL);

  assign st_s  = st_rdata;
  assign ext64 = 64'(st_s);

  pae_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  pae_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (ITEMS)
  ) u_scratch (
    .clk   (clk),
    .we    (sc_we),
    .waddr (pend_addr_r),
    .wdata (st_rdata),
    .raddr (idx_r),
    .rdata (sc_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= PW_NONE;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= cmd.resp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= in_word;
    end
    addr_r      <= addr_nxt;
    idx_r       <= idx_nxt;
    last_r      <= last_nxt;
    seg_r       <= seg_nxt;
    pend_addr_r <= pend_addr_nxt;
    if (cmd.resp) begin
      out_word_r.read_value <= ((req_r.operation == OP_READ) && !stat.err) ?
                               ext64[VAL_W-1:0] : '0;
      out_word_r.item_count <= CNT_OUT_W'(count_nxt);
      out_word_r.status     <= st_code;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ITEMS)) else $error("entry count above capacity");

  a_put_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put |-> (pend_r == PW_NONE)) else $error("store write port collision");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("result strobe longer than one cycle");

  a_count_on_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && $past(rst_n) && (count_r != $past(count_r))) |-> $past(cmd.resp))
    else $error("count changed outside result cycle");
`endif

endmodule

// ===== rtl/positional_array_editor.sv =====
// positional_array_editor: top level, controller plus datapath.
// Depends on pae_pkg, pae_ctrl, pae_dp (which holds two pae_ram instances).
//
// channel  ports                 handshake
// -------  --------------------  ------------------------------------------
// input    in_word               taken when start && !busy
// result   out_word              valid one cycle while out_valid, no stall
//
// One word at a time; busy covers the whole operation. A read or rejected
// word goes straight to the result; delete and insert run a shift pass if
// needed, insert then a flush and the put; swap a fill and a copy pass
// over second_end-first_start+1 entries; passes move one entry per cycle.
// out_valid rises the cycle busy falls. Reset clears the count and control
// only; store contents are undefined until written.
module positional_array_editor #(
  parameter int ITEMS     = pae_pkg::ITEMS_DEF,
  parameter int WORD_BITS = pae_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pae_pkg::in_word_t  in_word,
  output logic               out_valid,
  output pae_pkg::out_word_t out_word
);
  import pae_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pae_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  pae_dp #(
    .ITEMS     (ITEMS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
